// ----- rtl/cfd_pkg.sv -----
// Shared types and codes for the checksummed frame deframer.
`default_nettype none

package cfd_pkg;

    // Byte values that mark the preamble and the start code.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Reset value of the hunt limit register.
    localparam logic [7:0] HUNT_LIMIT_RESET = 8'd64;

    // Result kinds.
    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_ACCEPT  = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;

    // Rejection reasons.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_HUNT_FF    = 3'd1;
    localparam logic [2:0] ERR_HUNT_LIMIT = 3'd2;
    localparam logic [2:0] ERR_PREAMBLE   = 3'd3;
    localparam logic [2:0] ERR_START_CODE = 3'd4;
    localparam logic [2:0] ERR_LEN_CHECK  = 3'd5;
    localparam logic [2:0] ERR_DATA_CHECK = 3'd6;

    // Width of the packed result data, and that width rounded up to whole bytes.
    localparam int RES_DATA_W  = 27;
    localparam int RES_TDATA_W = 32;

    // One result beat as it leaves the parser.
    typedef struct packed {
        logic       valid;
        logic [1:0] event_res;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic [2:0] error_code;
    } cfd_res_t;

endpackage

`default_nettype wire

// ----- rtl/checksummed_frame_deframer.sv -----
// Top level of the checksummed frame deframer.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | tdata: rx_byte; tuser: frame_start
//  m_      | out       | tdata: out_byte, byte_index, frame_length, error_code;
//          |           | tuser: event_res
//  cfg_    | in        | data: hunt_limit
//
// One byte is taken per cycle while the output register is empty or m_tready
// is high; a byte's result is in the output register in the cycle after the
// byte is accepted, as only the output register lies between. Reset clears the
// parser to idle, empties the output register and loads the hunt limit with 64.
// While a result waits unclaimed, s_tready stays high only if m_tready is high.
`default_nettype none

module checksummed_frame_deframer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input beats: tdata[7:0] rx_byte
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,
    // tuser[0] frame_start
    input  wire logic [0:0]   s_tuser,
    // Result beats: tdata[7:0] out_byte, [15:8] byte_index, [23:16] frame_length,
    // [26:24] error_code, [31:27] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,
    // tuser[1:0] event_res
    output logic [1:0]        m_tuser,
    // Hunt limit register write
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data
);

    logic               cfg_take;
    logic [7:0]         hunt_limit_reg;
    logic               load_ok;
    logic               beat_take;
    cfd_pkg::cfd_res_t  res;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunt_limit_reg <= cfd_pkg::HUNT_LIMIT_RESET;
        end else if (cfg_take) begin
            hunt_limit_reg <= cfg_data;
        end
    end

    assign s_tready  = load_ok;
    assign beat_take = s_tvalid && s_tready;

    cfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_take   (beat_take),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser[0]),
        .hunt_limit  (hunt_limit_reg),
        .res         (res)
    );

    cfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/cfd_parser.sv -----
// Frame parser state machine: consumes one byte per accepted beat.
`default_nettype none

module cfd_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            beat_take,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            frame_start,
    input  wire logic [7:0]      hunt_limit,
    output cfd_pkg::cfd_res_t    res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HUNT  = 3'd1,
        PH_PRE2  = 3'd2,
        PH_START = 3'd3,
        PH_LEN   = 3'd4,
        PH_LCS   = 3'd5,
        PH_DATA  = 3'd6,
        PH_POST  = 3'd7
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] hunt_count_reg, hunt_count_next;
    logic [7:0] position_reg, position_next;

    // A start flag restarts the frame before this byte is looked at.
    phase_t     ph_eff;
    logic [7:0] rem_eff, sum_eff, len_eff, hunt_eff, pos_eff;

    always_comb begin
        ph_eff   = frame_start ? PH_HUNT : phase_reg;
        rem_eff  = frame_start ? 8'd0 : remaining_reg;
        sum_eff  = frame_start ? 8'd0 : sum_reg;
        len_eff  = frame_start ? 8'd0 : length_reg;
        hunt_eff = frame_start ? 8'd0 : hunt_count_reg;
        pos_eff  = frame_start ? 8'd0 : position_reg;
    end

    // Next state and the result for the current byte.
    always_comb begin
        phase_next      = ph_eff;
        remaining_next  = rem_eff;
        sum_next        = sum_eff;
        length_next     = len_eff;
        hunt_count_next = hunt_eff;
        position_next   = pos_eff;

        res              = '0;
        res.event_res    = cfd_pkg::EV_REJECT;
        res.error_code   = cfd_pkg::ERR_NONE;
        res.frame_length = len_eff;

        case (ph_eff)
            PH_HUNT: begin
                if (rx_byte == cfd_pkg::BYTE_ZERO) begin
                    phase_next = PH_PRE2;
                end else if (rx_byte == cfd_pkg::BYTE_ONES) begin
                    phase_next     = PH_IDLE;
                    res.valid      = 1'b1;
                    res.error_code = cfd_pkg::ERR_HUNT_FF;
                end else if (hunt_eff >= hunt_limit) begin
                    phase_next     = PH_IDLE;
                    res.valid      = 1'b1;
                    res.error_code = cfd_pkg::ERR_HUNT_LIMIT;
                end else begin
                    hunt_count_next = hunt_eff + 8'd1;
                end
            end
            PH_PRE2: begin
                if (rx_byte != cfd_pkg::BYTE_ZERO) begin
                    phase_next     = PH_IDLE;
                    res.valid      = 1'b1;
                    res.error_code = cfd_pkg::ERR_PREAMBLE;
                end else begin
                    phase_next = PH_START;
                end
            end
            PH_START: begin
                if (rx_byte != cfd_pkg::BYTE_ONES) begin
                    phase_next     = PH_IDLE;
                    res.valid      = 1'b1;
                    res.error_code = cfd_pkg::ERR_START_CODE;
                end else begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                length_next = rx_byte;
                phase_next  = PH_LCS;
            end
            PH_LCS: begin
                if (len_eff + rx_byte != 8'd0) begin
                    phase_next     = PH_IDLE;
                    res.valid      = 1'b1;
                    res.error_code = cfd_pkg::ERR_LEN_CHECK;
                end else begin
                    remaining_next = len_eff;
                    sum_next       = 8'd0;
                    position_next  = 8'd0;
                    phase_next     = PH_DATA;
                end
            end
            PH_DATA: begin
                if (rem_eff == 8'd0) begin
                    // Data-check byte closes the payload.
                    if (sum_eff + rx_byte != 8'd0) begin
                        phase_next     = PH_IDLE;
                        res.valid      = 1'b1;
                        res.error_code = cfd_pkg::ERR_DATA_CHECK;
                    end else begin
                        phase_next = PH_POST;
                    end
                end else begin
                    res.valid      = 1'b1;
                    res.event_res  = cfd_pkg::EV_PAYLOAD;
                    res.out_byte   = rx_byte;
                    res.byte_index = pos_eff;
                    sum_next       = sum_eff + rx_byte;
                    position_next  = pos_eff + 8'd1;
                    remaining_next = rem_eff - 8'd1;
                end
            end
            PH_POST: begin
                phase_next    = PH_IDLE;
                res.valid     = 1'b1;
                res.event_res = cfd_pkg::EV_ACCEPT;
            end
            default: begin
                // Idle: bytes without a start flag are dropped.
                phase_next = ph_eff;
            end
        endcase

        if (!beat_take) begin
            res.valid = 1'b0;
        end
    end

    // State update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            remaining_reg  <= 8'd0;
            sum_reg        <= 8'd0;
            length_reg     <= 8'd0;
            hunt_count_reg <= 8'd0;
            position_reg   <= 8'd0;
        end else if (beat_take) begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            sum_reg        <= sum_next;
            length_reg     <= length_next;
            hunt_count_reg <= hunt_count_next;
            position_reg   <= position_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cfd_out_reg.sv -----
// Result register between the parser and the master-side channel.
`default_nettype none

module cfd_out_reg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire cfd_pkg::cfd_res_t                  res,
    output logic                                    load_ok,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [cfd_pkg::RES_TDATA_W-1:0]         m_tdata,
    output logic [1:0]                              m_tuser
);

    logic                             valid_reg;
    logic [cfd_pkg::RES_DATA_W-1:0]   data_reg;
    logic [1:0]                       kind_reg;

    // A new beat may enter whenever the held one is gone or leaving now.
    assign load_ok = !valid_reg || m_tready;

    // Hold a result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ok) begin
            valid_reg <= res.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load_ok && res.valid) begin
            data_reg <= {res.error_code, res.frame_length, res.byte_index, res.out_byte};
            kind_reg <= res.event_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(cfd_pkg::RES_TDATA_W - cfd_pkg::RES_DATA_W){1'b0}}, data_reg};
    assign m_tuser  = kind_reg;

endmodule

`default_nettype wire
